// ===== rtl/sgtr_pkg.sv =====
// Shared types, constants and the 5x7 glyph table for the scaled glyph text renderer.
// Used by sgtr_raster and scaled_glyph_text_renderer. No dependencies.
package sgtr_pkg;

    localparam int GLYPH_W = 5;
    localparam int GLYPH_H = 7;

    // one row per entry, first row on top; bit 4 is the leftmost dot
    typedef logic [0:GLYPH_H-1][GLYPH_W-1:0] glyph_t;

    localparam logic [4:0]         SCALE_MIN  = 5'd1;
    localparam logic [4:0]         SCALE_MAX  = 5'd16;
    localparam logic signed [13:0] CURSOR_MAX = 14'sd8191;

    localparam logic [1:0] REG_GLYPH_SCALE  = 2'd0;
    localparam logic [1:0] REG_CHAR_SPACING = 2'd1;
    localparam logic [1:0] REG_DRAW_COLOR   = 2'd2;
    localparam logic [1:0] REG_BYTE_SWAP    = 2'd3;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_APOST   = 8'h27;

    localparam glyph_t FONT_DIGITS [10] = '{
        '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
        '{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
        '{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
        '{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
        '{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2 },
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
        '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
        '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8 },
        '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
        '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14}
    };

    localparam glyph_t FONT_LETTERS [26] = '{
        '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
        '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
        '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
        '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
        '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14},
        '{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31},
        '{5'd1,  5'd1,  5'd1,  5'd1,  5'd17, 5'd17, 5'd14},
        '{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
        '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
        '{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
        '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
        '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
        '{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
        '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
        '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
        '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4 },
        '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4 },
        '{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
        '{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
        '{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4 },
        '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31}
    };

    localparam glyph_t GLYPH_DASH  = '{5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0,  5'd0 };
    localparam glyph_t GLYPH_DOT   = '{5'd0, 5'd0, 5'd0, 5'd0,  5'd0, 5'd12, 5'd12};
    localparam glyph_t GLYPH_APOST = '{5'd4, 5'd4, 5'd0, 5'd0,  5'd0, 5'd0,  5'd0 };

    // fold lower case, then look up; codes without a glyph give an empty bitmap
    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        logic [7:0] c;
        glyph_t     g;
        c = code;
        g = '0;
        if (code >= CH_LOWER_A && code <= CH_LOWER_Z)
        begin
            c = code - (CH_LOWER_A - CH_UPPER_A);
        end
        priority if (c >= CH_ZERO && c <= CH_NINE)
        begin
            g = FONT_DIGITS[4'(c - CH_ZERO)];
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            g = FONT_LETTERS[5'(c - CH_UPPER_A)];
        end
        else if (c == CH_DASH)
        begin
            g = GLYPH_DASH;
        end
        else if (c == CH_DOT)
        begin
            g = GLYPH_DOT;
        end
        else if (c == CH_APOST)
        begin
            g = GLYPH_APOST;
        end
        else
        begin
            g = '0;
        end
        return g;
    endfunction

endpackage

// ===== rtl/scaled_glyph_text_renderer.sv =====
// Scaled 5x7 glyph text renderer: top level with configuration registers,
// item sequencer and result register. Uses sgtr_pkg, sgtr_raster, sgtr_store.
//
// Usage:
//   Input items arrive on the s_ stream (s_tuser = op, s_tdata = character, start
//   flag and coordinates); each item gives exactly one result on the m_ stream.
//   Configuration registers are written through cfg_we/cfg_index/cfg_wdata while
//   no item is in flight.
//   A draw item walks the 35 glyph dots, one per cycle while no lit dot holds the
//   rasterizer; a lit dot holds it for scale*scale pixel steps, with one pixel
//   write each for the pixels that fall inside the store. A read item goes
//   through the registered read port of the pixel store. s_tready is low while an
//   item is worked on. After reset the store is swept to zero, one word per cycle,
//   over all 2*PANEL_WIDTH*PANEL_HEIGHT words (261120 at the defaults); s_tready
//   stays low meanwhile and configuration writes are taken.
//   A stalled receiver holds the result in the output register; the next item
//   may be accepted and worked on, and its result waits until that register
//   frees up.
module scaled_glyph_text_renderer #(
    parameter int PANEL_WIDTH  = 480,
    parameter int PANEL_HEIGHT = 272
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // char_code[7:0], start_of_text[8], pos_x[20:9], pos_y[32:21]
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_data[15:0], in_range[16], cursor_pos[30:17]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    import sgtr_pkg::*;

    localparam int STORE_COLS = 2 * PANEL_WIDTH;
    localparam int AW         = $clog2(STORE_COLS * PANEL_HEIGHT);
    localparam int XW         = $clog2(STORE_COLS);
    localparam int YW         = $clog2(PANEL_HEIGHT);
    localparam logic signed [12:0] COLS_S = 13'(STORE_COLS);
    localparam logic signed [12:0] ROWS_S = 13'(PANEL_HEIGHT);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DRAW    = 3'd1;
    localparam logic [2:0] ST_RD_ADDR = 3'd2;
    localparam logic [2:0] ST_RD_DATA = 3'd3;
    localparam logic [2:0] ST_RESULT  = 3'd4;

    logic [4:0]         scale_reg;
    logic [5:0]         spacing_reg;
    logic [15:0]        color_reg;
    logic               swap_reg;

    logic [2:0]         state_reg,     state_next;
    logic signed [13:0] cursor_reg,    cursor_next;
    logic [15:0]        word_reg,      word_next;
    logic [AW-1:0]      rd_addr_reg,   rd_addr_next;
    logic               rd_hit_reg,    rd_hit_next;
    logic [15:0]        res_pixel_reg, res_pixel_next;
    logic               res_range_reg, res_range_next;
    logic               m_valid_reg,   m_valid_next;
    logic [31:0]        m_data_reg,    m_data_next;

    logic               in_op;
    logic [7:0]         in_char;
    logic               in_sot;
    logic signed [11:0] in_px;
    logic signed [11:0] in_py;
    logic               accept;
    logic [4:0]         scale_eff;
    logic [7:0]         advance;
    logic signed [14:0] cursor_sum;
    logic signed [13:0] cursor_sat;
    logic signed [13:0] org_x;
    logic signed [12:0] rx;
    logic signed [12:0] ry;
    logic               rd_hit;
    logic [AW-1:0]      rd_addr_calc;

    logic               raster_busy;
    logic               raster_done;
    logic               px_valid;
    logic [AW-1:0]      px_addr;
    logic [15:0]        rd_data;
    logic               store_ready;

    assign in_op   = s_tuser[0];
    assign in_char = s_tdata[7:0];
    assign in_sot  = s_tdata[8];
    assign in_px   = s_tdata[20:9];
    assign in_py   = s_tdata[32:21];

    assign s_tready = (state_reg == ST_IDLE) && store_ready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= 5'd1;
            spacing_reg <= 6'd1;
            color_reg   <= 16'hFFFF;
            swap_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GLYPH_SCALE:  scale_reg   <= cfg_wdata[4:0];
                REG_CHAR_SPACING: spacing_reg <= cfg_wdata[5:0];
                REG_DRAW_COLOR:   color_reg   <= cfg_wdata;
                REG_BYTE_SWAP:    swap_reg    <= cfg_wdata[0];
            endcase
        end
    end

    always_comb
    begin
        priority if (scale_reg < SCALE_MIN)
        begin
            scale_eff = SCALE_MIN;
        end
        else if (scale_reg > SCALE_MAX)
        begin
            scale_eff = SCALE_MAX;
        end
        else
        begin
            scale_eff = scale_reg;
        end
    end

    assign advance    = {1'b0, scale_eff, 2'b00} + {3'd0, scale_eff} + {2'd0, spacing_reg};
    assign cursor_sum = {cursor_reg[13], cursor_reg} + {7'd0, advance};
    assign cursor_sat = (cursor_sum > $signed({1'b0, CURSOR_MAX})) ? CURSOR_MAX
                                                                    : cursor_sum[13:0];
    assign org_x      = in_sot ? {{2{in_px[11]}}, in_px} : cursor_reg;

    assign rx     = {in_px[11], in_px};
    assign ry     = {in_py[11], in_py};
    assign rd_hit = !rx[12] && (rx < COLS_S) && !ry[12] && (ry < ROWS_S);
    assign rd_addr_calc = AW'(in_py[YW-1:0]) * AW'(STORE_COLS) + AW'(in_px[XW-1:0]);

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        word_next      = word_reg;
        rd_addr_next   = rd_addr_reg;
        rd_hit_next    = rd_hit_reg;
        res_pixel_next = res_pixel_reg;
        res_range_next = res_range_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_READ)
                    begin
                        rd_hit_next  = rd_hit;
                        rd_addr_next = rd_addr_calc;
                        state_next   = ST_RD_ADDR;
                    end
                    else
                    begin
                        cursor_next = org_x;
                        word_next   = swap_reg ? {color_reg[7:0], color_reg[15:8]} : color_reg;
                        state_next  = ST_DRAW;
                    end
                end
            end
            ST_DRAW:
            begin
                if (raster_done)
                begin
                    cursor_next    = cursor_sat;
                    res_pixel_next = 16'h0000;
                    res_range_next = 1'b1;
                    state_next     = ST_RESULT;
                end
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                res_pixel_next = rd_hit_reg ? rd_data : 16'h0000;
                res_range_next = rd_hit_reg;
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, cursor_reg, res_range_reg, res_pixel_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        rd_addr_reg   <= rd_addr_next;
        rd_hit_reg    <= rd_hit_next;
        res_pixel_reg <= res_pixel_next;
        res_range_reg <= res_range_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    sgtr_raster #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_raster (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && (in_op == OP_DRAW)),
        .glyph    (glyph_lookup(in_char)),
        .org_x    (org_x),
        .org_y    (in_py),
        .scale    (scale_eff),
        .busy     (raster_busy),
        .done     (raster_done),
        .px_valid (px_valid),
        .px_addr  (px_addr)
    );

    sgtr_store #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (px_valid),
        .wr_addr (px_addr),
        .wr_data (word_reg),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data),
        .ready   (store_ready)
    );

    a_raster_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
        raster_busy |-> state_reg == ST_DRAW)
        else $error("rasterizer running outside a draw");

    a_read_keeps_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_DATA) |=> $stable(cursor_reg))
        else $error("read item moved the cursor");

endmodule

// ===== rtl/sgtr_store.sv =====
// Pixel store: single-port-write, registered-read word memory covering both panels.
// Sweeps every word to zero after reset. No package dependencies.
module sgtr_store #(
    parameter int  PANEL_WIDTH  = 480,
    parameter int  PANEL_HEIGHT = 272,
    localparam int AW           = $clog2(2 * PANEL_WIDTH * PANEL_HEIGHT)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data,
    output logic          ready
);

    localparam int DEPTH = 2 * PANEL_WIDTH * PANEL_HEIGHT;

    logic [15:0]   mem [DEPTH];
    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    logic [15:0]   rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [15:0]   mem_data;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign mem_we   = clr_busy_reg | wr_en;
    assign mem_addr = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign mem_data = clr_busy_reg ? 16'h0000 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clr_busy_reg;

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !wr_en)
        else $error("pixel write during clearing pass");

    a_clear_covers_all: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> $past(clr_addr_reg) == AW'(DEPTH - 1))
        else $error("clearing pass ended early");

endmodule

// ===== rtl/sgtr_raster.sv =====
// Glyph rasterizer: a small sequencer that steps one dot or one pixel per cycle,
// clips against the store and issues pixel write addresses. Uses sgtr_pkg.
module sgtr_raster #(
    parameter int  PANEL_WIDTH  = 480,
    parameter int  PANEL_HEIGHT = 272,
    localparam int AW           = $clog2(2 * PANEL_WIDTH * PANEL_HEIGHT)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sgtr_pkg::glyph_t      glyph,
    input  logic signed [13:0]    org_x,
    input  logic signed [11:0]    org_y,
    input  logic [4:0]            scale,
    output logic                  busy,
    output logic                  done,
    output logic                  px_valid,
    output logic [AW-1:0]         px_addr
);

    import sgtr_pkg::*;

    localparam int STORE_COLS = 2 * PANEL_WIDTH;
    localparam int DEPTH      = STORE_COLS * PANEL_HEIGHT;
    localparam int XW         = $clog2(STORE_COLS);
    localparam int YW         = $clog2(PANEL_HEIGHT);
    localparam logic signed [14:0] COLS_S = 15'(STORE_COLS);
    localparam logic signed [12:0] ROWS_S = 13'(PANEL_HEIGHT);

    logic               busy_reg,     busy_next;
    logic               done_reg,     done_next;
    glyph_t             glyph_reg,    glyph_next;
    logic [4:0]         scale_reg,    scale_next;
    logic [3:0]         scale_m1_reg, scale_m1_next;
    logic [2:0]         row_reg,      row_next;
    logic [2:0]         col_reg,      col_next;
    logic [3:0]         sx_reg,       sx_next;
    logic [3:0]         sy_reg,       sy_next;
    logic signed [14:0] org_x_reg,    org_x_next;
    logic signed [14:0] dot_x_reg,    dot_x_next;
    logic signed [12:0] dot_y_reg,    dot_y_next;
    logic signed [14:0] pix_x_reg,    pix_x_next;
    logic signed [12:0] pix_y_reg,    pix_y_next;
    logic               px_valid_reg, px_valid_next;
    logic [AW-1:0]      px_addr_reg,  px_addr_next;

    logic               lit;
    logic               sx_last;
    logic               sy_last;
    logic               dot_end;
    logic               col_last;
    logic               row_last;
    logic               in_store;
    logic signed [14:0] step_x;
    logic signed [12:0] step_y;
    logic [AW-1:0]      addr_calc;

    assign lit      = glyph_reg[row_reg][3'(GLYPH_W - 1) - col_reg];
    assign sx_last  = (sx_reg == scale_m1_reg);
    assign sy_last  = (sy_reg == scale_m1_reg);
    assign dot_end  = !lit || (sx_last && sy_last);
    assign col_last = (col_reg == 3'(GLYPH_W - 1));
    assign row_last = (row_reg == 3'(GLYPH_H - 1));
    assign step_x   = {10'd0, scale_reg};
    assign step_y   = {8'd0, scale_reg};
    assign in_store = !pix_x_reg[14] && (pix_x_reg < COLS_S) &&
                      !pix_y_reg[12] && (pix_y_reg < ROWS_S);
    assign addr_calc = AW'(pix_y_reg[YW-1:0]) * AW'(STORE_COLS) + AW'(pix_x_reg[XW-1:0]);

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        glyph_next    = glyph_reg;
        scale_next    = scale_reg;
        scale_m1_next = scale_m1_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        org_x_next    = org_x_reg;
        dot_x_next    = dot_x_reg;
        dot_y_next    = dot_y_reg;
        pix_x_next    = pix_x_reg;
        pix_y_next    = pix_y_reg;
        px_valid_next = 1'b0;
        px_addr_next  = addr_calc;
        if (start)
        begin
            busy_next     = 1'b1;
            glyph_next    = glyph;
            scale_next    = scale;
            scale_m1_next = 4'(scale - 5'd1);
            row_next      = '0;
            col_next      = '0;
            sx_next       = '0;
            sy_next       = '0;
            org_x_next    = {org_x[13], org_x};
            dot_x_next    = {org_x[13], org_x};
            pix_x_next    = {org_x[13], org_x};
            dot_y_next    = {org_y[11], org_y};
            pix_y_next    = {org_y[11], org_y};
        end
        else if (busy_reg)
        begin
            px_valid_next = lit && in_store;
            if (dot_end)
            begin
                sx_next = '0;
                sy_next = '0;
                if (col_last)
                begin
                    col_next   = '0;
                    dot_x_next = org_x_reg;
                    pix_x_next = org_x_reg;
                    if (row_last)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        row_next   = row_reg + 3'd1;
                        dot_y_next = dot_y_reg + step_y;
                        pix_y_next = dot_y_reg + step_y;
                    end
                end
                else
                begin
                    col_next   = col_reg + 3'd1;
                    dot_x_next = dot_x_reg + step_x;
                    pix_x_next = dot_x_reg + step_x;
                    pix_y_next = dot_y_reg;
                end
            end
            else if (sx_last)
            begin
                sx_next    = '0;
                pix_x_next = dot_x_reg;
                sy_next    = sy_reg + 4'd1;
                pix_y_next = pix_y_reg + 13'sd1;
            end
            else
            begin
                sx_next    = sx_reg + 4'd1;
                pix_x_next = pix_x_reg + 15'sd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            px_valid_reg <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            sx_reg       <= '0;
            sy_reg       <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            px_valid_reg <= px_valid_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg    <= glyph_next;
        scale_reg    <= scale_next;
        scale_m1_reg <= scale_m1_next;
        org_x_reg    <= org_x_next;
        dot_x_reg    <= dot_x_next;
        dot_y_reg    <= dot_y_next;
        pix_x_reg    <= pix_x_next;
        pix_y_reg    <= pix_y_next;
        px_addr_reg  <= px_addr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign px_valid = px_valid_reg;
    assign px_addr  = px_addr_reg;

    a_addr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        px_valid_reg |-> px_addr_reg < AW'(DEPTH))
        else $error("pixel address beyond store");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished glyph");

endmodule
